// File: rtl/timing_error_histogram_monitor_macros.svh
// Assertion macros shared by the timing error histogram monitor RTL.
`ifndef TIMING_ERROR_HISTOGRAM_MONITOR_MACROS_SVH
`define TIMING_ERROR_HISTOGRAM_MONITOR_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define TEHM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define TEHM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tehm_pkg.sv
// Types, constants and helpers shared by the timing error histogram monitor.
package tehm_pkg;

  localparam int unsigned CountWidth = 32;
  localparam int unsigned NumBins    = 7;
  localparam int unsigned NumEdges   = NumBins - 1;
  localparam int unsigned BinW       = 3;
  localparam int unsigned ErrW       = 62;
  localparam int unsigned AluW       = 64;
  localparam int unsigned SecW       = 35;
  localparam int unsigned TotalW     = 32;

  localparam logic [ErrW-1:0] ErrMax   = {ErrW{1'b1}};
  localparam logic [29:0]     NsPerSec = 30'd1000000000;

  localparam logic [BinW-1:0] LastEdge = BinW'(NumEdges - 1);
  localparam logic [BinW-1:0] LastBin  = BinW'(NumBins - 1);

  // Configuration register indexes (byte address divided by four).
  localparam logic RegPeriodS  = 1'b0;
  localparam logic RegPeriodNs = 1'b1;

  typedef struct packed {
    logic [31:0] start_seconds;
    logic [29:0] start_nanoseconds;
    logic [31:0] end_seconds;
    logic [29:0] end_nanoseconds;
  } in_t;

  typedef struct packed {
    logic [ErrW-1:0]   error_ns;
    logic [ErrW-1:0]   largest_error_ns;
    logic [ErrW-1:0]   smallest_error_ns;
    logic [BinW-1:0]   bin_number;
    logic [TotalW-1:0] bin_total;
    logic              extreme_changed;
    logic              lone_bin;
    logic              report_due;
  } out_t;

  typedef struct packed {
    logic sub;
  } alu_ctrl_t;

  typedef struct packed {
    logic            upd;
    logic [BinW-1:0] bin;
  } bins_ctrl_t;

  typedef struct packed {
    logic [TotalW-1:0] total;
    logic              lone;
  } bins_stat_t;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_SEC_ADD = 10'b0000000010,
    ST_SEC_SUB = 10'b0000000100,
    ST_NS_ADD  = 10'b0000001000,
    ST_NS_SUB  = 10'b0000010000,
    ST_TOTAL   = 10'b0000100000,
    ST_ABS     = 10'b0001000000,
    ST_EXTREME = 10'b0010000000,
    ST_BIN     = 10'b0100000000,
    ST_COUNT   = 10'b1000000000
  } state_e;

  // Upper border of each of the first six histogram bins in nanoseconds.
  function automatic logic [AluW-1:0] bin_edge(input logic [BinW-1:0] idx);
    logic [AluW-1:0] edge_ns;
    case (idx)
      3'd0:    edge_ns = 64'd1000;
      3'd1:    edge_ns = 64'd10000;
      3'd2:    edge_ns = 64'd100000;
      3'd3:    edge_ns = 64'd1000000;
      3'd4:    edge_ns = 64'd10000000;
      default: edge_ns = 64'd100000000;
    endcase
    return edge_ns;
  endfunction

endpackage

// File: rtl/timing_error_histogram_monitor.sv
// Steps in order: seconds add and subtract, nanoseconds add and subtract, total, magnitude,
// extreme compare, bin search, count. One shared 64-bit adder does each sum and compare.
// The input side stalls from the accepting edge until the result enters the output register.
// Reset (asynchronous, active low) loads a period of 3 s, zeroes the maximum and all bin
// counters, sets the minimum to all ones and empties the output register.
module timing_error_histogram_monitor
  import tehm_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers. The user must write them only while the block is idle; the block does not enforce it.
  logic [31:0] period_s_q;
  logic [29:0] period_ns_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_s_q  <= 32'd3;
      period_ns_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        RegPeriodS:  period_s_q  <= pwdata;
        RegPeriodNs: period_ns_q <= pwdata[29:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegPeriodS:  prdata = period_s_q;
      RegPeriodNs: prdata = {2'b00, period_ns_q};
      default:     prdata = '0;
    endcase
  end

  // Sequencer state and working registers.
  state_e            state_q, state_d;
  in_t               in_q;
  logic [AluW-1:0]   acc_q, acc_d;
  logic [AluW-1:0]   prod_q;
  logic [ErrW-1:0]   err_q, err_d;
  logic [ErrW-1:0]   max_q, max_d;
  logic [ErrW-1:0]   min_q, min_d;
  logic              changed_q, changed_d;
  logic [BinW-1:0]   idx_q, idx_d;
  logic [BinW-1:0]   bin_q, bin_d;
  out_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              in_xfer;
  logic              slot_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The shared arithmetic unit and the operands that each step presents to it.
  logic [AluW-1:0] alu_a, alu_b, alu_sum;
  logic            alu_carry;
  alu_ctrl_t       alu_ctrl;

  tehm_alu u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .ctrl_i (alu_ctrl),
    .sum_o  (alu_sum),
    .carry_o(alu_carry)
  );

  // The seconds difference fits in 35 signed bits; scaling it to nanoseconds is the one
  // multiplication, registered before the total is formed.
  logic signed [SecW-1:0] sec_diff;
  logic signed [30:0]     ns_scale;
  logic signed [SecW+30:0] prod_full;

  assign sec_diff  = acc_q[SecW-1:0];
  assign ns_scale  = $signed({1'b0, NsPerSec});
  assign prod_full = sec_diff * ns_scale;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_NS_ADD) begin
      prod_q <= prod_full[AluW-1:0];
    end
  end

  // Histogram counters.
  bins_ctrl_t bins_ctrl;
  bins_stat_t bins_stat;

  assign bins_ctrl.upd = (state_q == ST_COUNT) && slot_free;
  assign bins_ctrl.bin = bin_q;

  tehm_bins #(
    .CountW(COUNT_WIDTH)
  ) u_bins (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(bins_ctrl),
    .stat_o(bins_stat)
  );

  // Operand selection for each step. The extreme step compares the error against the
  // maximum and the minimum in two passes of one state, tracked by the low index bit.
  always_comb begin
    alu_a        = '0;
    alu_b        = '0;
    alu_ctrl.sub = 1'b0;
    case (state_q)
      ST_SEC_ADD: begin
        alu_a = AluW'(period_s_q);
        alu_b = AluW'(in_q.start_seconds);
      end
      ST_SEC_SUB: begin
        alu_a        = acc_q;
        alu_b        = AluW'(in_q.end_seconds);
        alu_ctrl.sub = 1'b1;
      end
      ST_NS_ADD: begin
        alu_a = AluW'(period_ns_q);
        alu_b = AluW'(in_q.start_nanoseconds);
      end
      ST_NS_SUB: begin
        alu_a        = acc_q;
        alu_b        = AluW'(in_q.end_nanoseconds);
        alu_ctrl.sub = 1'b1;
      end
      ST_TOTAL: begin
        alu_a = prod_q;
        alu_b = acc_q;
      end
      ST_ABS: begin
        // A negative total is negated by subtracting it from zero.
        alu_a        = acc_q[AluW-1] ? '0 : acc_q;
        alu_b        = acc_q[AluW-1] ? acc_q : '0;
        alu_ctrl.sub = acc_q[AluW-1];
      end
      ST_EXTREME: begin
        alu_a        = idx_q[0] ? AluW'(err_q) : AluW'(max_q);
        alu_b        = idx_q[0] ? AluW'(min_q) : AluW'(err_q);
        alu_ctrl.sub = 1'b1;
      end
      ST_BIN: begin
        alu_a        = bin_edge(idx_q);
        alu_b        = AluW'(err_q);
        alu_ctrl.sub = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    err_d       = err_q;
    max_d       = max_q;
    min_d       = min_q;
    changed_d   = changed_q;
    idx_d       = idx_q;
    bin_d       = bin_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_SEC_ADD;
        end
      end
      ST_SEC_ADD: begin
        acc_d   = alu_sum;
        state_d = ST_SEC_SUB;
      end
      ST_SEC_SUB: begin
        acc_d   = alu_sum;
        state_d = ST_NS_ADD;
      end
      ST_NS_ADD: begin
        acc_d   = alu_sum;
        state_d = ST_NS_SUB;
      end
      ST_NS_SUB: begin
        acc_d   = alu_sum;
        state_d = ST_TOTAL;
      end
      ST_TOTAL: begin
        acc_d   = alu_sum;
        state_d = ST_ABS;
      end
      ST_ABS: begin
        // Magnitudes beyond the error field are clipped to its largest value.
        err_d     = (|alu_sum[AluW-1:ErrW]) ? ErrMax : alu_sum[ErrW-1:0];
        changed_d = 1'b0;
        idx_d     = '0;
        state_d   = ST_EXTREME;
      end
      ST_EXTREME: begin
        if (!alu_carry) begin
          changed_d = 1'b1;
          if (idx_q[0]) begin
            min_d = err_q;
          end else begin
            max_d = err_q;
          end
        end
        if (idx_q[0]) begin
          idx_d   = '0;
          state_d = ST_BIN;
        end else begin
          idx_d = idx_q + BinW'(1);
        end
      end
      ST_BIN: begin
        // The first border that is not below the error names the bin.
        if (alu_carry) begin
          bin_d   = idx_q;
          state_d = ST_COUNT;
        end else if (idx_q == LastEdge) begin
          bin_d   = LastBin;
          state_d = ST_COUNT;
        end else begin
          idx_d = idx_q + BinW'(1);
        end
      end
      ST_COUNT: begin
        if (slot_free) begin
          out_d.error_ns          = err_q;
          out_d.largest_error_ns  = max_q;
          out_d.smallest_error_ns = min_q;
          out_d.bin_number        = bin_q;
          out_d.bin_total         = bins_stat.total;
          out_d.extreme_changed   = changed_q;
          out_d.lone_bin          = bins_stat.lone;
          out_d.report_due        = changed_q || bins_stat.lone;
          out_valid_d             = 1'b1;
          state_d                 = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      max_q       <= '0;
      min_q       <= ErrMax;
      changed_q   <= 1'b0;
      idx_q       <= '0;
      bin_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      max_q       <= max_d;
      min_q       <= min_d;
      changed_q   <= changed_d;
      idx_q       <= idx_d;
      bin_q       <= bin_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
    acc_q <= acc_d;
    err_q <= err_d;
    out_q <= out_d;
  end

`include "timing_error_histogram_monitor_macros.svh"

  // A result only ever enters the output register from the counting step.
  `TEHM_ASSERT_IMP(a_out_from_count, $rose(out_valid_q), $past(state_q == ST_COUNT),
                   "result loaded outside the counting step")

  // Every reported error lies between the reported running minimum and maximum.
  `TEHM_ASSERT_IMP(a_err_in_range, out_valid_q,
                   (out_q.smallest_error_ns <= out_q.error_ns) &&
                   (out_q.error_ns <= out_q.largest_error_ns),
                   "error outside running extremes")

  // The bin number never exceeds the last bin.
  `TEHM_ASSERT_IMP(a_bin_valid, out_valid_q, out_q.bin_number <= LastBin,
                   "bin number out of range")

  // A changed extreme means the error equals the new maximum or the new minimum.
  `TEHM_ASSERT_IMP(a_changed_match, out_valid_q && out_q.extreme_changed,
                   (out_q.error_ns == out_q.largest_error_ns) ||
                   (out_q.error_ns == out_q.smallest_error_ns),
                   "extreme flag without matching extreme")

endmodule

// File: rtl/tehm_alu.sv
// Shared 64-bit adder and subtractor with an unsigned compare flag.
module tehm_alu
  import tehm_pkg::*;
(
  input  logic [AluW-1:0] a_i,
  input  logic [AluW-1:0] b_i,
  input  alu_ctrl_t       ctrl_i,
  output logic [AluW-1:0] sum_o,
  output logic            carry_o
);

  logic [AluW:0] full;

  // On a subtraction the carry out is set exactly when a is not below b.
  assign full = {1'b0, a_i} + {1'b0, (ctrl_i.sub ? ~b_i : b_i)} + (AluW+1)'(ctrl_i.sub);

  assign sum_o   = full[AluW-1:0];
  assign carry_o = full[AluW];

endmodule

// File: rtl/tehm_bins.sv
// Bank of saturating histogram bin counters with the lone-bin check.
module tehm_bins
  import tehm_pkg::*;
#(
  parameter int unsigned CountW = CountWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bins_ctrl_t ctrl_i,
  output bins_stat_t stat_o
);

  logic [CountW-1:0] cnt_q [NumBins];
  logic [CountW-1:0] cur;
  logic [CountW-1:0] nxt;
  logic [63:0]       nxt_wide;
  logic              others;

  always_comb begin
    cur    = '0;
    others = 1'b0;
    for (int i = 0; i < NumBins; i++) begin
      if (ctrl_i.bin == BinW'(i)) begin
        cur = cnt_q[i];
      end else if (cnt_q[i] != '0) begin
        others = 1'b1;
      end
    end
    nxt      = (cur == {CountW{1'b1}}) ? cur : cur + CountW'(1);
    nxt_wide = 64'(nxt);
  end

  // The reported total is clipped when the counters are wider than the field.
  assign stat_o.total = (|nxt_wide[63:TotalW]) ? {TotalW{1'b1}} : nxt_wide[TotalW-1:0];
  assign stat_o.lone  = ~others;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumBins; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (ctrl_i.upd) begin
      for (int i = 0; i < NumBins; i++) begin
        if (ctrl_i.bin == BinW'(i)) begin
          cnt_q[i] <= nxt;
        end
      end
    end
  end

endmodule

// File: tb/tb_timing_error_histogram_monitor.sv
// Self-checking testbench for the timing error histogram monitor.
`timescale 1ns / 1ps

module tb_timing_error_histogram_monitor;
  import tehm_pkg::*;

  // Nanoseconds in one second, and the highest start second that still leaves room
  // for at least one second of elapsed time in a 32-bit seconds field.
  localparam longint NsPerS  = 1000000000;
  localparam longint SecTop  = 64'hFFFF_FFFE;
  localparam int     CycleLimit = 400000;

  // Upper borders of the first six histogram bins; anything above the last one
  // lands in the final bin.
  localparam longint BorderNs [NumEdges] = '{1000, 10000, 100000, 1000000, 10000000,
                                             100000000};

  // Every input of the block holds a known value from time zero.
  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        in_valid = 1'b0;
  in_t         in_data  = '0;
  logic        out_stall = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;

  logic        in_stall;
  logic        out_valid;
  out_t        out_data;
  logic [31:0] prdata;
  logic        pready;

  timing_error_histogram_monitor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Our own copy of the block's configuration and histogram state. The state starts
  // at its reset values, and reset is applied only once at the beginning.
  logic [31:0]           period_s   = 32'd3;
  logic [29:0]           period_ns  = '0;
  logic [ErrW-1:0]       max_seen   = '0;
  logic [ErrW-1:0]       min_seen   = ErrMax;
  logic [CountWidth-1:0] bin_count [NumBins] = '{default: '0};

  // Timestamp pairs waiting to be driven, and reports still owed by the block.
  in_t  pending_stamps  [$];
  out_t pending_reports [$];

  int          queued_count   = 0;
  int          accepted_count = 0;
  int          mismatches     = 0;
  int          cycles         = 0;
  int unsigned send_gap_pct   = 37;
  int unsigned recv_stall_pct = 37;

  initial forever #5 clk_i = ~clk_i;

  // Absolute difference between the expected period and the elapsed time, in
  // nanoseconds. The nanosecond fields take part as given, with no carry into the
  // seconds, and the sum is formed signed so an end before the start is just a
  // larger error. The magnitude is clipped to the width of the error field.
  function automatic logic [ErrW-1:0] timing_error_ns(input in_t t);
    longint sec_diff, ns_diff, total;
    sec_diff = longint'(period_s) - (longint'(t.end_seconds) - longint'(t.start_seconds));
    ns_diff  = longint'(period_ns) - (longint'(t.end_nanoseconds) -
                                      longint'(t.start_nanoseconds));
    total    = sec_diff * NsPerS + ns_diff;
    if (total < 0) total = -total;
    if (total > longint'(ErrMax)) return ErrMax;
    return ErrW'(total);
  endfunction

  // Works out the report for one accepted timestamp pair and advances the running
  // extremes and the bin counters exactly as the block should.
  function automatic out_t predict_report(input in_t t);
    out_t            r;
    logic [ErrW-1:0] err;
    logic [BinW-1:0] bin;
    logic            others;
    r      = '0;
    err    = timing_error_ns(t);
    others = 1'b0;
    r.error_ns = err;
    if (err > max_seen) begin
      max_seen          = err;
      r.extreme_changed = 1'b1;
    end
    if (err < min_seen) begin
      min_seen          = err;
      r.extreme_changed = 1'b1;
    end
    // The first border that is not below the error picks the bin.
    bin = LastBin;
    for (int i = NumEdges - 1; i >= 0; i--) begin
      if (err <= BorderNs[i]) bin = BinW'(i);
    end
    // A lone bin means nothing else has been counted so far, before this increment.
    for (int j = 0; j < NumBins; j++) begin
      if (j != bin && bin_count[j] != '0) others = 1'b1;
    end
    if (bin_count[bin] != '1) bin_count[bin] = bin_count[bin] + 1'b1;
    r.bin_total         = (bin_count[bin] > {TotalW{1'b1}}) ? '1 : TotalW'(bin_count[bin]);
    r.largest_error_ns  = max_seen;
    r.smallest_error_ns = min_seen;
    r.bin_number        = bin;
    r.lone_bin          = !others;
    r.report_due        = r.extreme_changed | r.lone_bin;
    return r;
  endfunction

  function automatic string report_text(input out_t r);
    return $sformatf("err=%0d max=%0d min=%0d bin=%0d total=%0d chg=%0b lone=%0b due=%0b",
                     r.error_ns, r.largest_error_ns, r.smallest_error_ns, r.bin_number,
                     r.bin_total, r.extreme_changed, r.lone_bin, r.report_due);
  endfunction

  // Only the first ten mismatches are described; the rest are just counted.
  task automatic flag_mismatch(input string detail);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, detail);
  endtask

  // Produces one timestamp pair for the current period. Most pairs sit close to the
  // period with a deviation spread over every decade, so all bins and their exact
  // borders are visited; the rest are fully random fields, nanoseconds beyond one
  // second and ends before starts among them.
  function automatic in_t random_timestamps();
    in_t         t;
    longint      decade, dev, span, e_sec, e_ns;
    int unsigned dec;
    t      = '0;
    dec    = $urandom_range(0, 9);
    decade = 1;
    repeat (dec) decade = decade * 10;
    case ($urandom_range(0, 3))
      0:       dev = decade;
      1:       dev = decade + 1;
      default: dev = longint'($urandom) % (decade * 10);
    endcase
    if ($urandom_range(0, 1) == 1) dev = -dev;
    span = longint'(period_s) * NsPerS + longint'(period_ns) + dev;
    if (span < 0) span = -span;
    e_sec = span / NsPerS;
    e_ns  = span % NsPerS;
    if ($urandom_range(0, 99) < 25 || e_sec > SecTop) begin
      t.start_seconds     = $urandom;
      t.start_nanoseconds = 30'($urandom);
      t.end_seconds       = $urandom;
      t.end_nanoseconds   = 30'($urandom);
    end else begin
      t.start_nanoseconds = 30'($urandom_range(0, 999999999));
      t.start_seconds     = $urandom_range(0, 32'(SecTop - e_sec));
      e_ns = e_ns + longint'(t.start_nanoseconds);
      if (e_ns >= NsPerS) begin
        e_ns  = e_ns - NsPerS;
        e_sec = e_sec + 1;
      end
      t.end_seconds     = 32'(longint'(t.start_seconds) + e_sec);
      t.end_nanoseconds = 30'(e_ns);
    end
    return t;
  endfunction

  task automatic queue_stamp(input in_t t);
    pending_stamps.push_back(t);
    queued_count++;
  endtask

  task automatic queue_fields(input logic [31:0] ss, input logic [29:0] sn,
                              input logic [31:0] es, input logic [29:0] en);
    queue_stamp('{start_seconds: ss, start_nanoseconds: sn,
                  end_seconds: es, end_nanoseconds: en});
  endtask

  // Waits until every queued pair has been transferred and answered, then leaves the
  // block time to finish anything still in flight before the period may change.
  task automatic wait_until_idle();
    while (accepted_count != queued_count || pending_reports.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic run_phase(input int count);
    repeat (count) queue_stamp(random_timestamps());
    wait_until_idle();
  endtask

  // Reads a period register back over the configuration port. With pready held high
  // the data is taken at the edge that completes the access phase.
  task automatic check_period_reg(input logic idx);
    logic [31:0] want;
    want = (idx == RegPeriodS) ? period_s : 32'(period_ns);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want)
      flag_mismatch($sformatf("register %0d read back %0h, expected %0h", idx, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes a period register (setup cycle, then access cycle) and reads it back.
  task automatic write_period_reg(input logic idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegPeriodS) period_s = value;
    else period_ns = value[29:0];
    check_period_reg(idx);
  endtask

  // Input driver. A pair stays on the bus untouched until it is transferred; only
  // then, or while nothing is offered, does the driver decide whether to present the
  // next pair or to leave a gap. Each transfer is predicted on the spot, with the
  // period that is in force at that moment.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_reports.push_back(predict_report(in_data));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_stamps.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          in_data  <= pending_stamps.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The receiving side stalls at random, independently of what the block offers.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Result monitor: every transferred report is compared field by field with the
  // oldest outstanding prediction.
  always @(posedge clk_i) begin : report_check
    out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch({"unexpected report: ", report_text(out_data)});
      end else begin
        want = pending_reports.pop_front();
        if (out_data.error_ns          !== want.error_ns          ||
            out_data.largest_error_ns  !== want.largest_error_ns  ||
            out_data.smallest_error_ns !== want.smallest_error_ns ||
            out_data.bin_number        !== want.bin_number        ||
            out_data.bin_total         !== want.bin_total         ||
            out_data.extreme_changed   !== want.extreme_changed   ||
            out_data.lone_bin          !== want.lone_bin          ||
            out_data.report_due        !== want.report_due)
          flag_mismatch({"expected ", report_text(want), " got ", report_text(out_data)});
      end
    end
  end

  // Watchdog: a run that hangs is a failing run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset period of three seconds: confirm the reset values, then walk the error
    // across every bin border but the one at 1000000 ns, zero error, end before start
    // and out-of-range nanoseconds.
    check_period_reg(RegPeriodS);
    check_period_reg(RegPeriodNs);
    queue_fields(32'd0, 30'd0, 32'd0, 30'd0);
    queue_fields(32'd0, 30'd0, 32'd3, 30'd0);
    queue_fields(32'd0, 30'd0, 32'd2, 30'd999999000);
    queue_fields(32'd0, 30'd0, 32'd2, 30'd999998999);
    queue_fields(32'd0, 30'd0, 32'd2, 30'd999990000);
    queue_fields(32'd0, 30'd0, 32'd3, 30'd100000);
    queue_fields(32'd0, 30'd0, 32'd3, 30'd1000001);
    queue_fields(32'd0, 30'd0, 32'd3, 30'd10000000);
    queue_fields(32'd0, 30'd0, 32'd2, 30'd900000000);
    queue_fields(32'd0, 30'd0, 32'd2, 30'd899999999);
    queue_fields('1, '1, '1, '1);
    queue_fields('0, '0, '1, '1);
    queue_fields('1, '1, '0, '0);
    queue_fields(32'd5, 30'd0, 32'd7, '1);
    queue_fields(32'd7, 30'd999999999, 32'd10, 30'd999999999);
    queue_fields(32'd10, 30'd500, 32'd13, 30'd0);
    run_phase(200);

    // A zero period: any elapsed time at all is error.
    write_period_reg(RegPeriodS, 32'd0);
    write_period_reg(RegPeriodNs, 32'd0);
    queue_fields(32'd100, 30'd0, 32'd100, 30'd0);
    queue_fields(32'd0, 30'd1, 32'd0, 30'd0);
    queue_fields(32'd1, 30'd0, 32'd0, 30'd0);
    run_phase(150);

    // The largest period the registers hold; the upper bits of the nanosecond write
    // fall away. An end far before the start drives the error past its field width.
    write_period_reg(RegPeriodS, 32'hFFFF_FFFF);
    write_period_reg(RegPeriodNs, 32'hFFFF_FFFF);
    queue_fields('1, '0, '0, '1);
    queue_fields('1, '1, '0, '0);
    queue_fields('0, '0, '1, '1);
    queue_fields('0, '0, '0, '0);
    run_phase(150);

    // A long stretch with neither side idling, at the largest legal fraction.
    write_period_reg(RegPeriodS, 32'd1);
    write_period_reg(RegPeriodNs, 32'd999999999);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_phase(300);
    send_gap_pct   = 37;
    recv_stall_pct = 37;

    // Assorted periods, mostly a few seconds, now and then anything at all.
    repeat (4) begin
      write_period_reg(RegPeriodS,
                       ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5));
      write_period_reg(RegPeriodNs,
                       ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 999999999));
      run_phase(180);
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tehm_pkg.sv
rtl/tehm_alu.sv
rtl/tehm_bins.sv
rtl/timing_error_histogram_monitor.sv
tb/tb_timing_error_histogram_monitor.sv
